### design/fdl_pkg.sv
// Shared types, constants and saturation helpers for the fractional delay line.
// No dependencies; imported by fdl_seq and fractional_delay_line.
`default_nettype none

package fdl_pkg;

    localparam int MAX_DELAY      = 8192;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 30;
    localparam int ACC_FRAC       = 14;
    localparam int ACC_BITS       = 48;

    localparam int ADDR_BITS  = $clog2(MAX_DELAY);
    localparam int LEN_BITS   = 14;
    localparam int PROD_BITS  = COEF_BITS + SAMPLE_BITS;
    localparam int TERM_SHIFT = COEF_FRAC_BITS - ACC_FRAC;
    localparam int TERM_BITS  = PROD_BITS - TERM_SHIFT;
    localparam int TSUM_BITS  = TERM_BITS + 1;
    localparam int YW_BITS    = ACC_BITS + 1 - ACC_FRAC;
    localparam int ROUND_HALF = 1 << (ACC_FRAC - 1);

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ALLPASS_ENABLE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B0        = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B1        = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B2        = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A1        = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A2        = 3'd6;

    typedef logic [2:0] t_pc;

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_LOAD,   // fetch delayed sample into the filter input
        ALU_ACC,    // b0*x + first, saturated
        ALU_YO,     // round and saturate the output; latch b1*x
        ALU_T2,     // latch b2*x
        ALU_T1SUB,  // subtract a1*y
        ALU_FIN,    // state update, filtered sample out
        ALU_PASS    // unfiltered sample out
    } t_alu;

    typedef enum logic [2:0] {
        C_B0,
        C_B1,
        C_B2,
        C_A1,
        C_A2
    } t_coef;

    typedef enum logic {
        D_XIN,
        D_YO
    } t_dsel;

    typedef enum logic [1:0] {
        J_NEXT,
        J_BYPASS,  // jump when the filter is off
        J_END      // last step, waits for a free output register
    } t_jmp;

    typedef struct packed {
        t_alu  alu;
        logic  mul_en;
        t_coef coef;
        t_dsel dsel;
        t_jmp  jmp;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic start;
        logic bypass;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic   busy;
        t_uword uw;
    } t_ctrl;

    localparam t_uword UW_IDLE = '{alu: ALU_NOP, mul_en: 1'b0, coef: C_B0, dsel: D_XIN,
                                   jmp: J_NEXT, target: '0};

    function automatic logic signed [ACC_BITS-1:0] f_sat_acc(input logic signed [ACC_BITS:0] v);
        if (v[ACC_BITS] != v[ACC_BITS-1]) begin
            return v[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
        end
        return v[ACC_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] f_sat_sample(
        input logic signed [YW_BITS-1:0] v
    );
        if ((&v[YW_BITS-1:SAMPLE_BITS-1]) || !(|v[YW_BITS-1:SAMPLE_BITS-1])) begin
            return v[SAMPLE_BITS-1:0];
        end
        return v[YW_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} :
                              {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

endpackage

`default_nettype wire

### design/fdl_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
// Depends on fdl_pkg.
`default_nettype none

module fdl_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire fdl_pkg::t_stat i_stat,
    output fdl_pkg::t_ctrl     o_ctrl
);
    import fdl_pkg::*;

    logic   r_busy;
    t_pc    r_pc;
    t_uword w_uw;
    logic   w_fire;

    function automatic t_uword f_rom(input t_pc pc);
        t_uword uw;
        uw = UW_IDLE;
        case (pc)
            3'd0: begin
                uw.alu = ALU_LOAD; uw.jmp = J_BYPASS; uw.target = 3'd7;
            end
            3'd1: begin
                uw.mul_en = 1'b1; uw.coef = C_B0; uw.dsel = D_XIN;
            end
            3'd2: begin
                uw.alu = ALU_ACC; uw.mul_en = 1'b1; uw.coef = C_B1; uw.dsel = D_XIN;
            end
            3'd3: begin
                uw.alu = ALU_YO; uw.mul_en = 1'b1; uw.coef = C_B2; uw.dsel = D_XIN;
            end
            3'd4: begin
                uw.alu = ALU_T2; uw.mul_en = 1'b1; uw.coef = C_A1; uw.dsel = D_YO;
            end
            3'd5: begin
                uw.alu = ALU_T1SUB; uw.mul_en = 1'b1; uw.coef = C_A2; uw.dsel = D_YO;
            end
            3'd6: begin
                uw.alu = ALU_FIN; uw.jmp = J_END;
            end
            3'd7: begin
                uw.alu = ALU_PASS; uw.jmp = J_END;
            end
            default: begin
                uw = UW_IDLE;
            end
        endcase
        return uw;
    endfunction

    always_comb begin
        w_uw   = f_rom(r_pc);
        w_fire = r_busy && !(w_uw.jmp == J_END && !i_stat.out_free);
        o_ctrl.busy = r_busy;
        o_ctrl.uw   = w_fire ? w_uw : UW_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else if (!r_busy) begin
            if (i_stat.start) begin
                r_busy <= 1'b1;
                r_pc   <= '0;
            end
        end else if (w_fire) begin
            case (w_uw.jmp)
                J_END:    r_busy <= 1'b0;
                J_BYPASS: r_pc <= i_stat.bypass ? w_uw.target : r_pc + 3'd1;
                default:  r_pc <= r_pc + 3'd1;
            endcase
        end
    end

endmodule

`default_nettype wire

### design/fractional_delay_line.sv
// Fractional delay line: circular sample store followed by an optional allpass biquad.
// Depends on fdl_pkg and fdl_seq.
// One sample per beat. The beat is written into the store at the accept edge while the old
// sample is read; a microcoded sequencer then runs the biquad on one shared 32x24 multiplier,
// five products in a row. No new beat is taken until the item is done: load, five products
// and state update with the allpass on, load and pass with it off; the last step waits for a
// free output register. A finished sample waits there while the next beat is taken. The store
// needs no clearing after reset: a fill count marks written entries, unwritten ones read zero.
`default_nettype none

module fractional_delay_line (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // [23:0] sample_in
    input  wire logic        i_s_tlast,   // block_end
    // master side
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [23:0] sample_out
    output logic             o_m_tlast,   // block_end_out
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [fdl_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [fdl_pkg::COEF_BITS-1:0]     i_cfg_data
);
    import fdl_pkg::*;

    // configuration registers
    logic [LEN_BITS-1:0]         r_delay_length;
    logic                        r_allpass_enable;
    logic signed [COEF_BITS-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;

    // store
    logic [SAMPLE_BITS-1:0] mem [MAX_DELAY];
    logic [SAMPLE_BITS-1:0] r_rd;
    logic [ADDR_BITS-1:0]   r_pos;
    logic [LEN_BITS-1:0]    r_fill;
    logic                   r_use_store;
    logic                   r_hit;

    // item
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_last;

    // datapath
    logic signed [SAMPLE_BITS-1:0] r_xin;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [ACC_BITS-1:0]    r_acc;
    logic signed [SAMPLE_BITS-1:0] r_yo;
    logic signed [TSUM_BITS-1:0]   r_t1, r_t2;
    logic signed [ACC_BITS-1:0]    r_first, r_second;

    // output register
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_data;
    logic                   r_out_last;

    t_ctrl ctrl;
    t_stat stat;

    logic                          s_acc;
    logic [LEN_BITS-1:0]           w_len;
    logic [ADDR_BITS-1:0]          w_addr;
    logic [LEN_BITS-1:0]           w_nxt;
    logic signed [COEF_BITS-1:0]   w_coef;
    logic signed [SAMPLE_BITS-1:0] w_data;
    logic signed [PROD_BITS-1:0]   w_prod;
    logic signed [TERM_BITS-1:0]   w_term;
    logic signed [ACC_BITS:0]      w_acc_sum;
    logic signed [ACC_BITS:0]      w_rnd;
    logic signed [ACC_BITS:0]      w_s2;
    logic signed [ACC_BITS:0]      w_f1;

    assign o_s_tready = !ctrl.busy;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    assign stat.start    = s_acc;
    assign stat.bypass   = !r_allpass_enable;
    assign stat.out_free = !r_out_valid || i_m_tready;

    fdl_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // store addressing: a position left beyond a shortened length restarts at zero
    always_comb begin
        w_len  = (r_delay_length > LEN_BITS'(MAX_DELAY)) ? LEN_BITS'(MAX_DELAY)
                                                         : r_delay_length;
        w_addr = ({1'b0, r_pos} >= w_len) ? '0 : r_pos;
        w_nxt  = {1'b0, w_addr} + LEN_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_rd <= mem[w_addr];
            if (w_len != '0) begin
                mem[w_addr] <= i_s_tdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_fill <= '0;
        end else if (s_acc && w_len != '0) begin
            r_pos <= (w_nxt >= w_len) ? '0 : w_nxt[ADDR_BITS-1:0];
            // writes only ever extend the written prefix by one
            if ({1'b0, w_addr} == r_fill) begin
                r_fill <= r_fill + LEN_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_x         <= i_s_tdata;
            r_last      <= i_s_tlast;
            r_use_store <= (w_len != '0);
            r_hit       <= ({1'b0, w_addr} < r_fill);
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length   <= '0;
            r_allpass_enable <= 1'b0;
            r_b0 <= '0;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DELAY_LENGTH:   r_delay_length   <= i_cfg_data[LEN_BITS-1:0];
                REG_ALLPASS_ENABLE: r_allpass_enable <= i_cfg_data[0];
                REG_COEF_B0:        r_b0 <= i_cfg_data;
                REG_COEF_B1:        r_b1 <= i_cfg_data;
                REG_COEF_B2:        r_b2 <= i_cfg_data;
                REG_COEF_A1:        r_a1 <= i_cfg_data;
                REG_COEF_A2:        r_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared multiplier
    always_comb begin
        case (ctrl.uw.coef)
            C_B0:    w_coef = r_b0;
            C_B1:    w_coef = r_b1;
            C_B2:    w_coef = r_b2;
            C_A1:    w_coef = r_a1;
            C_A2:    w_coef = r_a2;
            default: w_coef = r_b0;
        endcase
        w_data = (ctrl.uw.dsel == D_YO) ? r_yo : r_xin;
        w_prod = w_coef * w_data;
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.uw.mul_en) begin
            r_prod <= w_prod;
        end
    end

    // product scaled to accumulator precision, floor
    always_comb begin
        w_term    = $signed(r_prod[PROD_BITS-1:TERM_SHIFT]);
        w_acc_sum = (ACC_BITS+1)'(w_term) + (ACC_BITS+1)'(r_first);
        w_rnd     = (ACC_BITS+1)'(r_acc) + (ACC_BITS+1)'(ROUND_HALF);
        w_s2      = (ACC_BITS+1)'(r_t2) - (ACC_BITS+1)'(w_term);
        w_f1      = (ACC_BITS+1)'(r_t1) + (ACC_BITS+1)'(r_second);
    end

    always_ff @(posedge i_clk) begin
        case (ctrl.uw.alu)
            ALU_LOAD:  r_xin <= r_use_store ? (r_hit ? r_rd : '0) : r_x;
            ALU_ACC:   r_acc <= f_sat_acc(w_acc_sum);
            ALU_YO: begin
                r_yo <= f_sat_sample(w_rnd[ACC_BITS:ACC_FRAC]);
                r_t1 <= TSUM_BITS'(w_term);
            end
            ALU_T2:    r_t2 <= TSUM_BITS'(w_term);
            ALU_T1SUB: r_t1 <= r_t1 - TSUM_BITS'(w_term);
            default: ;
        endcase
    end

    // filter state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= '0;
            r_second    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ctrl.uw.alu == ALU_FIN) begin
                r_second    <= f_sat_acc(w_s2);
                r_first     <= f_sat_acc(w_f1);
                r_out_valid <= 1'b1;
                r_out_data  <= r_yo;
                r_out_last  <= r_last;
            end else if (ctrl.uw.alu == ALU_PASS) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_xin;
                r_out_last  <= r_last;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LEN_BITS'(MAX_DELAY))
        else $error("fill count beyond store depth");

    a_pos_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && w_len != '0 |=> {1'b0, r_pos} < $past(w_len))
        else $error("read position not wrapped at length");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.uw.alu == ALU_FIN || ctrl.uw.alu == ALU_PASS) |-> (!r_out_valid || i_m_tready))
        else $error("result overwrote a waiting beat");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> ctrl.busy && ctrl.uw.alu == ALU_LOAD)
        else $error("sequencer did not start on accepted beat");

endmodule

`default_nettype wire
